FILE: design/cgeh_pkg.sv
`timescale 1ns / 1ps
package cgeh_pkg;

  // Histogram geometry
  localparam int TOP_BIN = 4095;
  localparam int NBINS   = TOP_BIN + 1;
  localparam int BIN_W   = $clog2(NBINS);

  // Field widths
  localparam int OP_W       = 2;
  localparam int TIME_W     = 64;
  localparam int ENERGY_W   = 24;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 32;
  localparam int WIN_W      = 32;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // Item operations
  localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
  localparam logic [OP_W-1:0] OP_EOE     = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESOLVE_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SHIFT      = 1'd1;

  typedef struct packed {
    logic in_ready;
    logic eval;
    logic update;
    logic push;
    logic clr_we;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
    logic            out_free;
  } status_t;

endpackage

FILE: design/cgeh_ifs.sv
`timescale 1ns / 1ps
interface cgeh_in_if import cgeh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [TIME_W-1:0]   dep_time;
  logic [ENERGY_W-1:0] dep_energy;
  logic [IDX_W-1:0]    bin_index;

  modport source(output valid, output op, output dep_time, output dep_energy,
                 output bin_index, input ready);
  modport sink(input valid, input op, input dep_time, input dep_energy,
               input bin_index, output ready);
endinterface

interface cgeh_out_if import cgeh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit_valid;
  logic [IDX_W-1:0] hit_bin;
  logic [CNT_W-1:0] bin_count;
  logic [CNT_W-1:0] hits_total;

  modport source(output valid, output hit_valid, output hit_bin, output bin_count,
                 output hits_total, input ready);
  modport sink(input valid, input hit_valid, input hit_bin, input bin_count,
               input hits_total, output ready);
endinterface

FILE: design/coincidence_grouped_energy_histogram.sv
`timescale 1ns / 1ps
// Coincidence-grouped energy histogram.
// in_ch (valid/ready) carries one item per transaction: a deposit (time, energy),
// an end of event, a bin read or a histogram clear. Deposits no farther apart than
// resolve_window ns are summed into one group; a larger gap or an end of event
// closes the group, and a closed group with a positive sum counts one hit in bin
// (sum >> bin_shift), clamped to the top bin which acts as overflow.
// out_ch returns exactly one result transaction per input transaction.
// cfg_we/cfg_index/cfg_wdata write resolve_window (0) and bin_shift (1), idle only.
// Timing: after the accepting edge the item passes through evaluate (histogram read),
// update (write-back) and output load, which waits until out_ch is free; in_ch is
// ready again the cycle after the load, so one item is in flight at a time, with the
// pace set by the single-port read-modify-write of the bin store. A clear item adds
// a sweep of all 4096 bins of the store, one bin per cycle, before its result.
// Reset: the same sweep runs after rst_n; in_ch.ready stays low during it.
// Stall: a result waits in the output register; the next item is accepted and
// processed while it waits, and holds before output until out_ch frees up.
module coincidence_grouped_energy_histogram import cgeh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cgeh_in_if.sink               in_ch,
  cgeh_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer: sweep, accept, evaluate, update, push
  cgeh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = cmd.in_ready;

  // group tracking, bin store, counters and output register
  cgeh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_op          (in_ch.op),
    .in_dep_time    (in_ch.dep_time),
    .in_dep_energy  (in_ch.dep_energy),
    .in_bin_index   (in_ch.bin_index),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_hit_valid  (out_ch.hit_valid),
    .out_hit_bin    (out_ch.hit_bin),
    .out_bin_count  (out_ch.bin_count),
    .out_hits_total (out_ch.hits_total)
  );

endmodule

FILE: design/cgeh_ctrl.sv
`timescale 1ns / 1ps
module cgeh_ctrl import cgeh_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       clr_op_r, clr_op_nxt;  // sweep was requested by an item

  always_comb begin
    state_nxt  = state_r;
    clr_op_nxt = clr_op_r;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_nxt  = clr_op_r ? S_UPD : S_IDLE;
          clr_op_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.op == OP_CLEAR) begin
          state_nxt  = S_CLEAR;
          clr_op_nxt = 1'b1;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

endmodule

FILE: design/cgeh_dp.sv
`timescale 1ns / 1ps
module cgeh_dp import cgeh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // item in
  input  logic                  in_valid,
  input  logic [OP_W-1:0]       in_op,
  input  logic [TIME_W-1:0]     in_dep_time,
  input  logic [ENERGY_W-1:0]   in_dep_energy,
  input  logic [IDX_W-1:0]      in_bin_index,
  // result out
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_hit_valid,
  output logic [IDX_W-1:0]      out_hit_bin,
  output logic [CNT_W-1:0]      out_bin_count,
  output logic [CNT_W-1:0]      out_hits_total
);

  logic [CNT_W-1:0] hist_mem [NBINS];

  logic [OP_W-1:0]     op_r;
  logic [TIME_W-1:0]   time_r;
  logic [ENERGY_W-1:0] energy_r;
  logic [IDX_W-1:0]    idx_r;

  logic [WIN_W-1:0]   win_r;
  logic [SHIFT_W-1:0] shift_r;

  logic [CNT_W-1:0]  sum_r, hitcnt_r;
  logic [TIME_W-1:0] last_r;
  logic              open_r;

  logic             hit_r, close_r, idx_ok_r;
  logic [BIN_W-1:0] bin_r;
  logic [CNT_W-1:0] rd_r;
  logic [BIN_W-1:0] clr_addr_r;

  logic             out_valid_r, out_hit_r;
  logic [IDX_W-1:0] out_bin_r;
  logic [CNT_W-1:0] out_count_r, out_total_r;

  // eval stage
  logic [TIME_W-1:0] gap;
  logic              gap_gt, is_dep, close_c, hit_c, idx_ok_c;
  logic [CNT_W-1:0]  shifted;
  logic [BIN_W-1:0]  bin_c, rd_addr;

  assign is_dep   = (op_r == OP_DEPOSIT) && (energy_r != '0);
  assign gap      = time_r - last_r;
  assign gap_gt   = (time_r >= last_r) && (gap > {{(TIME_W-WIN_W){1'b0}}, win_r});
  assign close_c  = (is_dep && open_r && gap_gt) || (op_r == OP_EOE);
  assign hit_c    = close_c && open_r && (sum_r != '0);
  assign shifted  = sum_r >> shift_r;
  assign bin_c    = (shifted > CNT_W'(TOP_BIN)) ? BIN_W'(TOP_BIN) : BIN_W'(shifted);
  assign idx_ok_c = ({20'd0, idx_r} <= 32'(TOP_BIN));
  assign rd_addr  = (op_r == OP_READ) ? BIN_W'(idx_r) : bin_c;

  // update stage
  logic [CNT_W-1:0] sum_base, hitcnt_nxt, bin_inc;
  logic [CNT_W:0]   sum_add;

  assign sum_base = close_r ? '0 : sum_r;
  assign sum_add  = {1'b0, sum_base} + {{(CNT_W+1-ENERGY_W){1'b0}}, energy_r};
  assign bin_inc  = (rd_r == CNT_SAT) ? rd_r : rd_r + 1'b1;

  always_comb begin
    hitcnt_nxt = hitcnt_r;
    if (op_r == OP_CLEAR) hitcnt_nxt = '0;
    else if (hit_r && hitcnt_r != CNT_SAT) hitcnt_nxt = hitcnt_r + 1'b1;
  end

  // histogram store: sweep clear, read in eval, write back in update
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      hist_mem[clr_addr_r] <= '0;
    end else if (cmd.update && hit_r) begin
      hist_mem[bin_r] <= bin_inc;
    end
    if (cmd.eval) rd_r <= hist_mem[rd_addr];
  end

  // item capture and eval results
  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_valid) begin
      op_r     <= in_op;
      time_r   <= in_dep_time;
      energy_r <= in_dep_energy;
      idx_r    <= in_bin_index;
    end
    if (cmd.eval) begin
      hit_r    <= hit_c;
      close_r  <= close_c;
      bin_r    <= bin_c;
      idx_ok_r <= idx_ok_c;
    end
  end

  // config and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= WIN_W'(1000);
      shift_r    <= SHIFT_W'(8);
      sum_r      <= '0;
      last_r     <= '0;
      open_r     <= 1'b0;
      hitcnt_r   <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RESOLVE_WINDOW: win_r   <= cfg_wdata[WIN_W-1:0];
          REG_BIN_SHIFT:      shift_r <= cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_we) begin
        clr_addr_r <= status.clr_last ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.update) begin
        hitcnt_r <= hitcnt_nxt;
        if (is_dep) begin
          sum_r  <= sum_add[CNT_W] ? CNT_SAT : sum_add[CNT_W-1:0];
          open_r <= 1'b1;
          last_r <= time_r;
        end else if (op_r == OP_EOE) begin
          sum_r  <= '0;
          open_r <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_hit_r   <= hit_r;
      out_bin_r   <= hit_r ? IDX_W'(bin_r) : '0;
      out_count_r <= (op_r == OP_READ && idx_ok_r) ? rd_r : '0;
      out_total_r <= hitcnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_valid  = out_hit_r;
  assign out_hit_bin    = out_bin_r;
  assign out_bin_count  = out_count_r;
  assign out_hits_total = out_total_r;

  assign status.op       = op_r;
  assign status.clr_last = (clr_addr_r == BIN_W'(TOP_BIN));
  assign status.out_free = !out_valid_r || out_ready;

endmodule

FILE: bench/tb_coincidence_grouped_energy_histogram.sv
`timescale 1ns / 1ps
module tb_coincidence_grouped_energy_histogram;
  import cgeh_pkg::*;

  // Run ceiling in clock cycles. The slowest legal run is far below this even with
  // every clear sweep, the reset sweep and the long receiver hold-offs.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
  localparam int SETTLE      = 8;

  // One input transaction and one result transaction
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   dep_time;
    logic [ENERGY_W-1:0] dep_energy;
    logic [IDX_W-1:0]    bin_index;
  } mca_item_t;

  typedef struct packed {
    logic             hit_valid;
    logic [IDX_W-1:0] hit_bin;
    logic [CNT_W-1:0] bin_count;
    logic [CNT_W-1:0] hits_total;
  } mca_result_t;

  // Directed row: item plus an optional hand-written result
  typedef struct packed {
    mca_item_t   item;
    logic        fixed;
    mca_result_t result;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cgeh_in_if  in_ch ();
  cgeh_out_if out_ch ();

  coincidence_grouped_energy_histogram dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the bin store, the hit tally, the open
  // coincidence group and the two registers.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   bin_store [NBINS];
  logic [CNT_W-1:0]   hit_tally;
  logic [CNT_W-1:0]   group_energy;
  logic [TIME_W-1:0]  prev_dep_time;
  logic               group_live;
  logic [WIN_W-1:0]   window_ns;
  logic [SHIFT_W-1:0] energy_shift;
  logic [IDX_W-1:0]   recent_bin;     // last bin hit, steers bin reads

  mca_result_t expected_results [$];  // oldest first
  dir_row_t    dir_tab [$];

  int errors;
  int cycles;
  int useful_sent;      // transactions that do something (zero-energy deposits excluded)
  int tx_idle_pct;      // sender idle chance per cycle
  int rx_stall_pct;     // receiver stall chance per cycle
  int hold_requests;    // bumped by stimulus, served by the receiver
  int hold_served;
  int hold_left;
  logic [TIME_W-1:0] clock_ns;  // running deposit time of the stimulus

  // Close the open group; a positive sum books one hit in its bin.
  function automatic void close_group(inout mca_result_t r);
    logic [CNT_W-1:0] b;
    if (group_live && group_energy != '0) begin
      b = group_energy >> energy_shift;
      if (b > TOP_BIN) b = TOP_BIN;
      if (bin_store[b] != CNT_SAT) bin_store[b] = bin_store[b] + 1;
      if (hit_tally != CNT_SAT) hit_tally = hit_tally + 1;
      r.hit_valid = 1'b1;
      r.hit_bin   = b[IDX_W-1:0];
      recent_bin  = b[IDX_W-1:0];
    end
    group_live   = 1'b0;
    group_energy = '0;
  endfunction

  // Advance the predictor by one accepted item and return its result.
  function automatic mca_result_t tally_item(mca_item_t it);
    mca_result_t       r;
    logic [TIME_W-1:0] gap;
    logic [CNT_W:0]    sum;
    r = '0;
    case (it.op)
      OP_DEPOSIT: begin
        // zero energy is dropped without touching time or group
        if (it.dep_energy != '0) begin
          if (group_live) begin
            // time running backward counts as no gap
            gap = (it.dep_time >= prev_dep_time) ? it.dep_time - prev_dep_time : '0;
            if (gap > {{(TIME_W-WIN_W){1'b0}}, window_ns}) close_group(r);
          end
          sum = {1'b0, group_energy} + {{(CNT_W+1-ENERGY_W){1'b0}}, it.dep_energy};
          group_energy  = sum[CNT_W] ? CNT_SAT : sum[CNT_W-1:0];
          group_live    = 1'b1;
          prev_dep_time = it.dep_time;
        end
      end
      OP_EOE: begin
        close_group(r);
      end
      OP_READ: begin
        if (it.bin_index <= TOP_BIN) r.bin_count = bin_store[it.bin_index];
      end
      default: begin
        // clear leaves an open group alone
        for (int i = 0; i < NBINS; i++) bin_store[i] = '0;
        hit_tally = '0;
      end
    endcase
    r.hits_total = hit_tally;
    return r;
  endfunction

  function automatic dir_row_t row(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                                   logic [ENERGY_W-1:0] e, logic [IDX_W-1:0] idx,
                                   int fixed, int hv, int hb, int cnt, int tot);
    dir_row_t d;
    d.item   = '{op, t, e, idx};
    d.fixed  = (fixed != 0);
    d.result = '{(hv != 0), IDX_W'(hb), CNT_W'(cnt), CNT_W'(tot)};
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called right after a rising edge, returns right after the edge at
  // which the transaction was taken. valid is only lowered for idle cycles, so
  // back-to-back transactions never see a low/high pair in one time step.
  // ---------------------------------------------------------------------------
  task automatic offer_item(mca_item_t it, logic fixed, mca_result_t fixed_res);
    mca_result_t r;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.dep_time   <= it.dep_time;
    in_ch.dep_energy <= it.dep_energy;
    in_ch.bin_index  <= it.bin_index;
    do @(posedge clk); while (!in_ch.ready);
    r = tally_item(it);
    expected_results.push_back(fixed ? fixed_res : r);
    if (!(it.op == OP_DEPOSIT && it.dep_energy == '0)) useful_sent++;
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic set_config(logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] shift_data);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESOLVE_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_index <= REG_BIN_SHIFT;
    cfg_wdata <= shift_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ns    = win[WIN_W-1:0];
    energy_shift = shift_data[SHIFT_W-1:0];  // upper data bits are don't-care
    @(posedge clk);
  endtask

  // Next deposit time: mostly within the window or just past its edge, sometimes far, sometimes back.
  task automatic step_clock();
    case ($urandom_range(9))
      0, 1, 2, 3: clock_ns = clock_ns + $urandom_range(0, window_ns >> 1);
      4:          clock_ns = clock_ns + window_ns;
      5:          clock_ns = clock_ns + {32'd0, window_ns} + 64'd1;
      6:          ;  // same time stamp
      7:          clock_ns = clock_ns + {$urandom, $urandom};
      8:          clock_ns = clock_ns + $urandom;
      default:    clock_ns = clock_ns - $urandom_range(1, 2000);
    endcase
  endtask

  function automatic logic [ENERGY_W-1:0] pick_energy();
    logic [ENERGY_W-1:0] e;
    case ($urandom_range(19))
      0:       e = '0;
      1:       e = '1;
      default: e = ENERGY_W'($urandom & ((32'd1 << $urandom_range(1, ENERGY_W)) - 1));
    endcase
    return e;
  endfunction

  // Mostly well-formed events (a run of deposits, usually an end of event),
  // mixed with bin reads, rare clears and arbitrary noise transactions.
  task automatic random_traffic(int n_items);
    int          goal;
    int          pick;
    int          k;
    mca_item_t   it;
    mca_result_t none;
    none = '0;
    goal = useful_sent + n_items;
    while (useful_sent < goal) begin
      pick = $urandom_range(99);
      // unused fields carry noise, the block must ignore them
      it.dep_time   = {$urandom, $urandom};
      it.dep_energy = ENERGY_W'($urandom);
      it.bin_index  = IDX_W'($urandom);
      if (pick < 2) begin
        it.op = OP_CLEAR;
        offer_item(it, 1'b0, none);
      end else if (pick < 10) begin
        it.op = OP_READ;
        if ($urandom_range(1)) it.bin_index = recent_bin;
        offer_item(it, 1'b0, none);
      end else if (pick < 16) begin
        it.op = OP_W'($urandom_range(0, 2));
        if (it.op == OP_DEPOSIT) clock_ns = it.dep_time;
        offer_item(it, 1'b0, none);
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          step_clock();
          it.op         = OP_DEPOSIT;
          it.dep_time   = clock_ns;
          it.dep_energy = pick_energy();
          offer_item(it, 1'b0, none);
        end
        if ($urandom_range(9) < 7) begin
          it.op = OP_EOE;
          offer_item(it, 1'b0, none);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern plus result checking, all sampled at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mca_result_t want;
    mca_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.hit_valid, out_ch.hit_bin, out_ch.bin_count, out_ch.hits_total};
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result transaction: hv=%0d bin=%0d cnt=%0d tot=%0d",
                 $time, got.hit_valid, got.hit_bin, got.bin_count, got.hits_total);
      end else begin
        want = expected_results.pop_front();
        if (got.hit_valid !== want.hit_valid || got.hit_bin !== want.hit_bin ||
            got.bin_count !== want.bin_count || got.hits_total !== want.hits_total) begin
          errors++;
          $display("%0t mismatch: expected hv=%0d bin=%0d cnt=%0d tot=%0d, actual hv=%0d bin=%0d cnt=%0d tot=%0d",
                   $time, want.hit_valid, want.hit_bin, want.bin_count, want.hits_total,
                   got.hit_valid, got.hit_bin, got.bin_count, got.hits_total);
        end
      end
    end
    // long hold-off requested by the stimulus, counted here
    if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_DEPOSIT;
    in_ch.dep_time   = '0;
    in_ch.dep_energy = '0;
    in_ch.bin_index  = '0;
    out_ch.ready     = 1'b0;
    errors           = 0;
    cycles           = 0;
    useful_sent      = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_requests    = 0;
    hold_served      = 0;
    hold_left        = 0;
    for (int i = 0; i < NBINS; i++) bin_store[i] = '0;
    hit_tally     = '0;
    group_energy  = '0;
    prev_dep_time = '0;
    group_live    = 1'b0;
    window_ns     = WIN_W'(1000);
    energy_shift  = SHIFT_W'(8);
    recent_bin    = '0;

    // Directed rows, reset registers (window 1000 ns, shift 8).
    //                op          time                    energy       idx     fix hv hb    cnt tot
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'd0,   1, 0, 0,    0, 0));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'hFFF, 1, 0, 0,    0, 0));
    // end of event with nothing open
    dir_tab.push_back(row(OP_EOE,     64'd0,                 24'd0,       12'd0,   1, 0, 0,    0, 0));
    // zero-energy deposit is dropped
    dir_tab.push_back(row(OP_DEPOSIT, 64'd100,               24'd0,       12'd0,   1, 0, 0,    0, 0));
    dir_tab.push_back(row(OP_DEPOSIT, 64'd1000,              24'h000100,  12'd0,   1, 0, 0,    0, 0));
    // gap exactly the window still joins
    dir_tab.push_back(row(OP_DEPOSIT, 64'd2000,              24'h000200,  12'd0,   1, 0, 0,    0, 0));
    // time going backward joins
    dir_tab.push_back(row(OP_DEPOSIT, 64'd500,               24'h000100,  12'd0,   1, 0, 0,    0, 0));
    // gap of window+1 closes: 0x400 >> 8 = bin 4
    dir_tab.push_back(row(OP_DEPOSIT, 64'd1501,              24'h000100,  12'd0,   1, 1, 4,    0, 1));
    dir_tab.push_back(row(OP_EOE,     64'd0,                 24'd0,       12'd0,   1, 1, 1,    0, 2));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'd4,   1, 0, 0,    1, 2));
    dir_tab.push_back(row(OP_DEPOSIT, '1,                    24'hFFFFFF,  12'd0,   1, 0, 0,    0, 2));
    dir_tab.push_back(row(OP_DEPOSIT, '1,                    24'hFFFFFF,  12'd0,   1, 0, 0,    0, 2));
    // large sum lands in the overflow bin
    dir_tab.push_back(row(OP_EOE,     64'd0,                 24'd0,       12'd0,   1, 1, 4095, 0, 3));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'hFFF, 1, 0, 0,    1, 3));
    dir_tab.push_back(row(OP_DEPOSIT, 64'd0,                 24'd1,       12'd0,   1, 0, 0,    0, 3));
    dir_tab.push_back(row(OP_EOE,     64'd0,                 24'd0,       12'd0,   1, 1, 0,    0, 4));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'd0,   1, 0, 0,    1, 4));
    // clear with a group open: the group survives
    dir_tab.push_back(row(OP_DEPOSIT, 64'd10,                24'h000500,  12'd0,   1, 0, 0,    0, 4));
    dir_tab.push_back(row(OP_CLEAR,   64'd0,                 24'd0,       12'd0,   1, 0, 0,    0, 0));
    dir_tab.push_back(row(OP_EOE,     64'd0,                 24'd0,       12'd0,   1, 1, 5,    0, 1));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'd5,   1, 0, 0,    1, 1));
    dir_tab.push_back(row(OP_READ,    64'd0,                 24'd0,       12'd0,   1, 0, 0,    0, 1));
    dir_tab.push_back(row(OP_DEPOSIT, 64'hAAAA_5555_0F0F_F0F0, 24'h5A5A5A, 12'hFFF, 0, 0, 0,    0, 0));
    dir_tab.push_back(row(OP_DEPOSIT, 64'hAAAA_5555_0F0F_F4D8, 24'hA5A5A5, 12'h000, 0, 0, 0,    0, 0));
    dir_tab.push_back(row(OP_EOE,     64'h5555_AAAA_F0F0_0F0F, 24'h0,      12'h555, 0, 0, 0,    0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling; the reset sweep holds ready low for a while.
    foreach (dir_tab[i]) offer_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].result);
    wait_for_idle();

    // Smallest window and shift, no idling on either side.
    clock_ns = {$urandom, $urandom};
    set_config(32'd0, 32'd0);
    random_traffic(200);
    wait_for_idle();

    // Largest window, largest nominal shift, sender mostly idle.
    set_config(32'hFFFF_FFFF, 32'd16);
    tx_idle_pct = 83;
    random_traffic(200);
    wait_for_idle();

    // Nominal settings, receiver mostly stalled, plus one long hold-off while
    // the sender keeps pushing so the input side backs up.
    set_config(32'd1000, 32'd8);
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    hold_requests++;
    random_traffic(200);
    wait_for_idle();

    // Random window, shift data with junk in the upper bits, both sides idling.
    set_config($urandom, $urandom);
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    random_traffic(100);
    wait_for_idle();    // sender pause until everything is back
    random_traffic(100);
    wait_for_idle();

    // Shift of 31 and a pile-up of maximum deposits at one time stamp:
    // the group sum saturates before the end of event closes it.
    set_config($urandom_range(0, 5000), 32'd31);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    clock_ns     = {$urandom, $urandom};
    repeat (300) offer_item('{OP_DEPOSIT, clock_ns, 24'hFFFFFF, 12'd0}, 1'b0, '0);
    offer_item('{OP_EOE, 64'd0, 24'd0, 12'd0}, 1'b0, '0);
    tx_idle_pct = 30;
    random_traffic(100);
    wait_for_idle();

    // Tiny window, fine bins, both idling, another long hold-off.
    set_config(32'd1, 32'd4);
    rx_stall_pct = 30;
    hold_requests++;
    random_traffic(200);
    wait_for_idle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
